### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, switched off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same, for a property that must also hold while reset is low.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/dcrc_pkg.sv
// ----------------------------------------------------------------------------
// Dual CRC-16 checker package
// Transaction types and the byte-wide CRC-16 (0x8005) update functions.
// ----------------------------------------------------------------------------
package dcrc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8005;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_last;
        logic [15:0] reference_crc;
    } dcrc_in_t;

    typedef struct packed {
        logic        ref_hit;
        logic [15:0] crc_msb_first;
        logic [15:0] crc_reflected;
    } dcrc_out_t;

    // Control of the held input transaction, seen by the CRC engine
    typedef struct packed {
        logic valid;
        logic last;
    } dcrc_stage_ctl_t;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[7 - k];
        end
        return r;
    endfunction

    function automatic logic [15:0] flip16(input logic [15:0] v);
        logic [15:0] r;
        for (int k = 0; k < 16; k++) begin
            r[k] = v[15 - k];
        end
        return r;
    endfunction

    // Fold one byte in, MSB first, eight steps unrolled
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  byte_in);
        logic [15:0] crc;
        crc = crc_in;
        for (int k = 7; k >= 0; k--) begin
            if (crc[15] ^ byte_in[k]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

### hw/rtl/dcrc_input_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one incoming transaction until the CRC engine consumes it.
// ----------------------------------------------------------------------------
module dcrc_input_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  dcrc_pkg::dcrc_in_t         in_data,
    input  logic                       advance,
    output dcrc_pkg::dcrc_stage_ctl_t  ctl,
    output dcrc_pkg::dcrc_in_t         held
);
    import dcrc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    dcrc_in_t data_reg;

    // Take a new transaction whenever the slot is empty or being drained
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.last  = data_reg.is_last;
    assign held      = data_reg;

endmodule

### hw/rtl/dcrc_crc_engine.sv
// ----------------------------------------------------------------------------
// CRC engine
// Running BUYPASS and ARC CRC registers, compare, and the result register.
// ----------------------------------------------------------------------------
module dcrc_crc_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dcrc_pkg::dcrc_stage_ctl_t  ctl,
    input  dcrc_pkg::dcrc_in_t         held,
    output logic                       advance,
    output logic                       out_valid,
    input  logic                       out_ready,
    output dcrc_pkg::dcrc_out_t        out_data
);
    import dcrc_pkg::*;

    logic [15:0] crc_forward_reg;
    logic [15:0] crc_forward_next;
    logic [15:0] crc_reversed_reg;
    logic [15:0] crc_reversed_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    dcrc_out_t   out_data_reg;
    dcrc_out_t   result;
    logic [15:0] fwd_upd;
    logic [15:0] rev_upd;

    assign fwd_upd = crc_feed(crc_forward_reg, held.data_byte);
    assign rev_upd = crc_feed(crc_reversed_reg, flip8(held.data_byte));

    always_comb
    begin
        result.crc_msb_first = fwd_upd;
        result.crc_reflected = flip16(rev_upd);
        result.ref_hit       = (fwd_upd == held.reference_crc) ||
                               (result.crc_reflected == held.reference_crc);
    end

    // A last byte waits only while the result register is still occupied
    assign advance = ctl.valid && (!ctl.last || !out_valid_reg || out_ready);

    always_comb
    begin
        crc_forward_next  = crc_forward_reg;
        crc_reversed_next = crc_reversed_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        if (advance) begin
            if (ctl.last) begin
                crc_forward_next  = '0;
                crc_reversed_next = '0;
                out_valid_next    = 1'b1;
            end
            else begin
                crc_forward_next  = fwd_upd;
                crc_reversed_next = rev_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_forward_reg  <= '0;
            crc_reversed_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else begin
            crc_forward_reg  <= crc_forward_next;
            crc_reversed_reg <= crc_reversed_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctl.last) begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### hw/rtl/dual_crc16_region_checker.sv
// A last byte's transaction is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while no last byte is stalled; both CRC-16 updates are unrolled
// between the input register and the result register, with no register inside the running CRC loop.
// A last byte stalls only while the previous result has not been taken.
// Reset: rst_n (asynchronous, active low) clears both CRC registers and all valids.
// ----------------------------------------------------------------------------
// Dual CRC-16 region checker
// Streams region bytes through BUYPASS and ARC CRC-16 and checks a reference.
// ----------------------------------------------------------------------------
module dual_crc16_region_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dcrc_pkg::dcrc_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dcrc_pkg::dcrc_out_t  out_data
);
    import dcrc_pkg::*;

    dcrc_stage_ctl_t ctl;
    dcrc_in_t        held;
    logic            advance;

    dcrc_input_stage u_input (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .advance  (advance),
        .ctl      (ctl),
        .held     (held)
    );

    dcrc_crc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .held      (held),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### hw/rtl/dcrc_checker.sv
// ----------------------------------------------------------------------------
// Dual CRC-16 checker assertions
// Port-level checks on stalling, latency and result hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcrc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input dcrc_pkg::dcrc_in_t   in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input dcrc_pkg::dcrc_out_t  out_data
);
    import dcrc_pkg::*;

    // Input is held back only by a result that is waiting to be taken
    `ASSERT_CLK(a_stall_cause, clk, rst_n, !in_ready |-> (out_valid && !out_ready), "input stalled without a pending result")

    // A fresh result follows a last byte that was taken at the input
    `ASSERT_CLK(a_latency, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready && in_data.is_last, 2), "result without a last byte two cycles before")

    // A waiting result transaction holds
    `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "result dropped or changed while stalled")

endmodule

bind dual_crc16_region_checker dcrc_checker u_dcrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
